@@ hw/rtl/ipr_pkg.sv @@
// Shared constants and controller/datapath interface types for the inversion parity block.
`timescale 1ns / 1ps
`default_nettype none

package ipr_pkg;

   localparam int DEF_MAX_ELEMENTS = 1024;
   localparam int DEF_VALUE_BITS   = 16;

   localparam int VALUE_W = 16;
   localparam int POS_W   = 11;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic clear;
      logic store;
      logic pass_start;
      logic pass_step;
      logic query;
   } ipr_cmd_type;

   typedef struct packed {
      logic pass_end;
      logic rsp_full;
   } ipr_stat_type;

endpackage

`default_nettype wire

@@ hw/rtl/ipr_dpath.sv @@
// Datapath: element memory, fill count, pair-pass counters and compare, parity and result register.
`timescale 1ns / 1ps
`default_nettype none

module ipr_dpath #(
   parameter int MAX_ELEMENTS = ipr_pkg::DEF_MAX_ELEMENTS,
   parameter int VALUE_BITS   = ipr_pkg::DEF_VALUE_BITS
) (
   input  wire                         clock,
   input  wire                         reset,
   input  ipr_pkg::ipr_cmd_type        cmd,
   output ipr_pkg::ipr_stat_type       stat,
   input  wire [ipr_pkg::VALUE_W-1:0]  req_value,
   input  wire [ipr_pkg::POS_W-1:0]    req_left_pos,
   input  wire [ipr_pkg::POS_W-1:0]    req_right_pos,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output logic                        rsp_parity_odd
);
   import ipr_pkg::*;

   localparam int CW = $clog2(MAX_ELEMENTS + 1);
   localparam int PW = CW + 1;
   localparam int IW = $clog2(MAX_ELEMENTS);

   logic [VALUE_BITS-1:0] mem [MAX_ELEMENTS];

   logic [CW-1:0]         count_ff, count_in, count_base;
   logic [PW-1:0]         outer_ff, outer_in, inner_ff, inner_in, cnt_ext;
   logic [VALUE_BITS-1:0] a_ff, b_ff;
   logic                  cmp_vld_ff, cmp_vld_in;
   logic                  parity_ff, parity_in;
   logic                  rsp_vld_ff, rsp_vld_in;
   logic                  rsp_par_ff;
   logic                  wr_en, rd_en, row_more, not_full;
   logic [IW-1:0]         wr_addr;
   logic [1:0]            len_lo;

   assign count_base = cmd.clear ? '0 : count_ff;
   assign not_full   = (count_base != CW'(MAX_ELEMENTS));
   assign wr_en      = cmd.store && not_full;
   assign wr_addr    = count_base[IW-1:0];
   assign count_in   = wr_en ? count_base + CW'(1) : count_base;

   assign cnt_ext  = PW'(count_ff);
   assign row_more = (inner_ff < cnt_ext);
   assign rd_en    = cmd.pass_step && row_more;

   // one pair per cycle along a row; a row change reads no pair
   always_comb begin
      outer_in   = outer_ff;
      inner_in   = inner_ff;
      cmp_vld_in = rd_en;
      if (cmd.pass_start) begin
         outer_in = '0;
         inner_in = PW'(1);
      end else if (cmd.pass_step) begin
         if (row_more) begin
            inner_in = inner_ff + PW'(1);
         end else begin
            outer_in = outer_ff + PW'(1);
            inner_in = outer_ff + PW'(2);
         end
      end
   end

   // segment of length L flips parity when L mod 4 is 2 or 3
   assign len_lo = req_right_pos[1:0] - req_left_pos[1:0] + 2'd1;

   always_comb begin
      parity_in = parity_ff;
      if (cmd.clear) begin
         parity_in = 1'b0;
      end
      if (cmp_vld_ff && (a_ff > b_ff)) begin
         parity_in = ~parity_in;
      end
      if (cmd.query && len_lo[1]) begin
         parity_in = ~parity_in;
      end
   end

   assign rsp_vld_in = cmd.query || (rsp_vld_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= VALUE_BITS'(req_value);
      end
      if (rd_en) begin
         a_ff <= mem[outer_ff[IW-1:0]];
         b_ff <= mem[inner_ff[IW-1:0]];
      end
      if (cmd.query) begin
         rsp_par_ff <= parity_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         outer_ff   <= '0;
         inner_ff   <= '0;
         cmp_vld_ff <= 1'b0;
         parity_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         outer_ff   <= outer_in;
         inner_ff   <= inner_in;
         cmp_vld_ff <= cmp_vld_in;
         parity_ff  <= parity_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   assign stat.pass_end = ((outer_ff + PW'(1)) >= cnt_ext);
   assign stat.rsp_full = rsp_vld_ff;

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_parity_odd = rsp_par_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ELEMENTS))
      else $error("fill count beyond memory depth");

   a_no_cmp_on_beat: assert property (@(posedge clock) disable iff (reset)
      (cmd.store || cmd.query) |-> !cmp_vld_ff)
      else $error("compare still in flight when a beat is taken");

endmodule

`default_nettype wire

@@ hw/rtl/ipr_ctrl.sv @@
// Controller: phase state machine, input handshake and datapath commands.
`timescale 1ns / 1ps
`default_nettype none

module ipr_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire                    req_operation,
   input  wire                    req_last,
   input  wire                    rsp_stall,
   input  ipr_pkg::ipr_stat_type  stat,
   output ipr_pkg::ipr_cmd_type   cmd
);
   import ipr_pkg::*;

   localparam logic [1:0] ST_LOAD  = 2'd0;
   localparam logic [1:0] ST_PASS  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_QUERY = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       busy, out_block, accept;

   assign busy      = (state_ff == ST_PASS) || (state_ff == ST_DRAIN);
   assign out_block = stat.rsp_full && rsp_stall;
   // loads never produce a beat, so only a query waits on the result register
   assign req_stall = busy || ((req_operation == OP_QUERY) && out_block);
   assign accept    = req_valid && !req_stall;

   assign cmd.store      = accept && (req_operation == OP_LOAD);
   assign cmd.clear      = cmd.store && (state_ff == ST_QUERY);
   assign cmd.pass_start = cmd.store && req_last;
   assign cmd.pass_step  = (state_ff == ST_PASS) && !stat.pass_end;
   assign cmd.query      = accept && (req_operation == OP_QUERY) && (state_ff == ST_QUERY);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (cmd.pass_start) state_in = ST_PASS;
         end
         ST_PASS: begin
            if (stat.pass_end) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_QUERY;
         end
         ST_QUERY: begin
            if (cmd.pass_start) begin
               state_in = ST_PASS;
            end else if (cmd.store) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      busy |-> req_stall)
      else $error("input taken during pair pass");

   a_last_starts_pass: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_operation == OP_LOAD) && req_last)
      |=> (state_ff == ST_PASS))
      else $error("final load did not start the pair pass");

   a_drain_to_query: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |=> (state_ff == ST_QUERY))
      else $error("drain did not end in query phase");

endmodule

`default_nettype wire

@@ hw/rtl/inversion_parity_with_reversals.sv @@
// Inversion parity block top level: controller and datapath.
//
// Input channel req_*: one beat per cycle while req_stall is low. A load
// beat (req_operation 0) appends req_value to the sequence; values past
// MAX_ELEMENTS are dropped. A load with req_last set starts the pair pass,
// which compares every pair i < j of stored elements, one pair per cycle
// along a row from a two-read memory; a row change reads no pair. The
// row loop of the pass and the drain state after it hold req_stall high.
// A query beat (req_operation 1) after the pass flips the parity when the
// segment length mod 4 is 2 or 3 and returns a rsp_* beat the next cycle.
// A query before the pass is dropped without a result. A load after the
// pass starts a new sequence with parity cleared.
// Throughput is one beat per cycle outside the pass. While rsp_stall holds
// a result, loads are still taken; a query waits until the result moves.
// Reset empties the sequence, clears parity and returns to loading.
`timescale 1ns / 1ps
`default_nettype none

module inversion_parity_with_reversals #(
   parameter int MAX_ELEMENTS = ipr_pkg::DEF_MAX_ELEMENTS,
   parameter int VALUE_BITS   = ipr_pkg::DEF_VALUE_BITS
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_stall,
   input  wire                         req_operation,
   input  wire [ipr_pkg::VALUE_W-1:0]  req_value,
   input  wire                         req_last,
   input  wire [ipr_pkg::POS_W-1:0]    req_left_pos,
   input  wire [ipr_pkg::POS_W-1:0]    req_right_pos,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output logic                        rsp_parity_odd
);
   import ipr_pkg::*;

   ipr_cmd_type  cmd;
   ipr_stat_type stat;

   ipr_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_last      (req_last),
      .rsp_stall     (rsp_stall),
      .stat          (stat),
      .cmd           (cmd)
   );

   ipr_dpath #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .VALUE_BITS   (VALUE_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_value      (req_value),
      .req_left_pos   (req_left_pos),
      .req_right_pos  (req_right_pos),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_parity_odd (rsp_parity_odd)
   );

endmodule

`default_nettype wire

@@ test/ipr_checker.sv @@
// Result checker for the inversion parity block: tracks the sequence, predicts query parities.
`timescale 1ns / 1ps

module ipr_checker (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   input  wire                         req_stall,
   input  wire                         req_operation,
   input  wire [ipr_pkg::VALUE_W-1:0]  req_value,
   input  wire                         req_last,
   input  wire [ipr_pkg::POS_W-1:0]    req_left_pos,
   input  wire [ipr_pkg::POS_W-1:0]    req_right_pos,
   input  wire                         rsp_valid,
   input  wire                         rsp_stall,
   input  wire                         rsp_parity_odd,
   output int                          fail_count,
   output int                          pending
);
   import ipr_pkg::*;

   localparam int SEQ_DEPTH = DEF_MAX_ELEMENTS;

   typedef enum logic {SEQ_LOADING, SEQ_QUERYING} seq_phase_type;

   logic [VALUE_W-1:0] seq_mem [SEQ_DEPTH];
   int unsigned        seq_len   = 0;
   logic               parity    = 1'b0;
   seq_phase_type      seq_phase = SEQ_LOADING;
   logic               parity_q [$];
   int                 errors    = 0;

   // parity of the number of pairs i < j with seq_mem[i] > seq_mem[j]
   function automatic logic inversion_parity();
      logic p;
      p = 1'b0;
      for (int i = 0; i + 1 < seq_len; i++)
         for (int j = i + 1; j < seq_len; j++)
            if (seq_mem[i] > seq_mem[j]) p = ~p;
      return p;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
   endtask

   task automatic predict_beat();
      logic [1:0] len4;
      if (req_operation == OP_LOAD) begin
         // first load after the pass starts a fresh sequence
         if (seq_phase != SEQ_LOADING) begin
            seq_len   = 0;
            parity    = 1'b0;
            seq_phase = SEQ_LOADING;
         end
         if (seq_len < SEQ_DEPTH) begin
            seq_mem[seq_len] = req_value;
            seq_len++;
         end
         if (req_last) begin
            parity    = parity ^ inversion_parity();
            seq_phase = SEQ_QUERYING;
         end
      end else if (seq_phase == SEQ_QUERYING) begin
         // segment length mod 4, wrapping; 2 or 3 flips the parity
         len4 = req_right_pos[1:0] - req_left_pos[1:0] + 2'd1;
         if (len4[1]) parity = ~parity;
         parity_q.push_back(parity);
      end
   endtask

   always @(posedge clock) begin
      logic want;
      if (reset) begin
         seq_len   = 0;
         parity    = 1'b0;
         seq_phase = SEQ_LOADING;
         parity_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (parity_q.size() == 0) begin
               report_mismatch("result beat with nothing expected");
            end else begin
               want = parity_q.pop_front();
               if (rsp_parity_odd !== want)
                  report_mismatch($sformatf("parity_odd got %b want %b", rsp_parity_odd, want));
            end
         end
         if (req_valid && !req_stall) predict_beat();
      end
      pending    <= parity_q.size();
      fail_count <= errors;
   end

endmodule

@@ test/tb.sv @@
// Testbench top for the inversion parity block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
   import ipr_pkg::*;

   localparam int RESET_CYCLES = 9;
   localparam int IDLE_LIMIT   = 1_600_000;  // well above the stall of a full-store pass
   localparam int HOLD_CYCLES  = 250;
   localparam int DRAIN_CYCLES = 16;
   localparam int RANDOM_ITEMS = 32;

   logic               clock         = 1'b0;
   logic               reset         = 1'b1;
   logic               req_valid     = 1'b0;
   logic               req_operation = OP_LOAD;
   logic [VALUE_W-1:0] req_value     = '0;
   logic               req_last      = 1'b0;
   logic [POS_W-1:0]   req_left_pos  = '0;
   logic [POS_W-1:0]   req_right_pos = '0;
   logic               rsp_stall     = 1'b0;
   wire                req_stall;
   wire                rsp_valid;
   wire                rsp_parity_odd;

   int fail_count;
   int pending;
   int snd_idle_pct  = 0;
   int rcv_stall_pct = 0;
   int hold_request  = 0;
   int beat_count    = 0;
   int idle_cycles   = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   inversion_parity_with_reversals dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_value      (req_value),
      .req_last       (req_last),
      .req_left_pos   (req_left_pos),
      .req_right_pos  (req_right_pos),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_parity_odd (rsp_parity_odd)
   );

   ipr_checker chk (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_value      (req_value),
      .req_last       (req_last),
      .req_left_pos   (req_left_pos),
      .req_right_pos  (req_right_pos),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_parity_odd (rsp_parity_odd),
      .fail_count     (fail_count),
      .pending        (pending)
   );

   // result side: random stall, or a long hold-off counted here on request
   initial begin : receiver
      int seen;
      int hold_left;
      seen      = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request != seen) begin
            seen      = hold_request;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_beat(input logic op, input logic [VALUE_W-1:0] value, input logic last,
                            input logic [POS_W-1:0] left, input logic [POS_W-1:0] right);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_value     <= value;
      req_last      <= last;
      req_left_pos  <= left;
      req_right_pos <= right;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic load_beat(input logic [VALUE_W-1:0] value, input logic last);
      send_beat(OP_LOAD, value, last, POS_W'($urandom()), POS_W'($urandom()));
   endtask

   task automatic query_beat(input logic [POS_W-1:0] left, input logic [POS_W-1:0] right);
      send_beat(OP_QUERY, VALUE_W'($urandom()), 1'($urandom()), left, right);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // bias toward duplicates and the ends of the range
   function automatic logic [VALUE_W-1:0] pick_value();
      int sel;
      sel = $urandom_range(3);
      case (sel)
         0:       return VALUE_W'($urandom_range(3));
         1:       return {VALUE_W{1'b1}} - VALUE_W'($urandom_range(3));
         default: return VALUE_W'($urandom());
      endcase
   endfunction

   task automatic random_query(input int n);
      int sel;
      int left;
      int right;
      sel = $urandom_range(9);
      if (sel == 0) begin
         query_beat(POS_W'($urandom()), POS_W'($urandom()));
      end else if (sel == 1) begin
         left = $urandom_range(1, DEF_MAX_ELEMENTS);
         query_beat(POS_W'(left), POS_W'(left - 1));
      end else begin
         left  = $urandom_range(1, n);
         right = $urandom_range(left, n);
         query_beat(POS_W'(left), POS_W'(right));
      end
   endtask

   task automatic run_sequence(input int n, input int queries);
      for (int i = 0; i < n; i++) begin
         // stray query mid-load, dropped by the block
         if (i > 0 && $urandom_range(15) == 0) random_query(n);
         load_beat(pick_value(), i == n - 1);
      end
      for (int q = 0; q < queries; q++) random_query(n);
      beat_count += n + queries;
   endtask

   task automatic random_phase(input int snd_pct, input int rcv_pct, input int items);
      int target;
      snd_idle_pct  = snd_pct;
      rcv_stall_pct = rcv_pct;
      target        = beat_count + items;
      while (beat_count < target)
         run_sequence(($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12),
                      $urandom_range(0, 14));
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      query_beat(1, 1);                 // no pass yet: dropped
      load_beat({VALUE_W{1'b1}}, 1'b0);
      load_beat('0, 1'b0);
      load_beat(16'h8000, 1'b0);
      load_beat(16'h0001, 1'b1);
      query_beat(1, 1);
      query_beat(1, 2);
      query_beat(1, 3);
      query_beat(1, 4);
      query_beat(1, POS_W'(DEF_MAX_ELEMENTS));
      query_beat(POS_W'(DEF_MAX_ELEMENTS), POS_W'(DEF_MAX_ELEMENTS));
      query_beat(2, 1);                 // right below left wraps to length 0
      query_beat({POS_W{1'b1}}, '0);
      query_beat('0, {POS_W{1'b1}});
      query_beat({POS_W{1'b1}}, {POS_W{1'b1}});
      load_beat(16'h1234, 1'b1);        // restart with a one-element sequence
      query_beat(3, 4);
      load_beat(16'h0005, 1'b0);
      query_beat(1, 2);                 // still loading: dropped
      load_beat(16'h0005, 1'b0);
      load_beat(16'h0004, 1'b1);
      query_beat(1, 3);
      wait_drained();

      // overfill the store; extra loads are dropped, the pass covers the full store
      run_sequence(DEF_MAX_ELEMENTS + 6, 8);
      wait_drained();

      random_phase(0, 0, RANDOM_ITEMS / 4);

      // long receiver hold while queries keep coming, so the input backs up
      hold_request++;
      for (int k = 0; k < 12; k++) random_query(4);
      wait_drained();

      random_phase(46, 0, RANDOM_ITEMS / 4);
      random_phase(0, 46, RANDOM_ITEMS / 4);
      random_phase(9, 9, RANDOM_ITEMS / 4);
      for (int k = 0; k < 4; k++) random_query(8);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
